FILE: sv/efj_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Euler flux and Jacobian unit package
// Shared constants, status codes and the pipeline control group.
// ----------------------------------------------------------------------------
package efj_pkg;

  localparam int unsigned DefWordBits = 32;
  localparam int unsigned DefFracBits = 16;

  localparam int unsigned HeatBits = 18;
  localparam int unsigned HeatFracBits = 16;
  localparam logic [HeatBits-1:0] HeatReset = 18'd91750;

  localparam int unsigned DivStepsPerStage = 8;

  localparam int unsigned AddrBits = 3;
  localparam logic RegHeatRatio = 1'b0;

  typedef enum logic [1:0] {
    StatusOk         = 2'd0,
    StatusBadDensity = 2'd1,
    StatusSaturated  = 2'd2
  } status_e;

  typedef struct packed {
    logic valid;
    logic bad;
    logic clip;
  } efj_ctl_t;

endpackage
`default_nettype wire

FILE: sv/efj_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined dual divider
// Two restoring divisions by one positive divisor, a fixed number of quotient
// bits per stage, with saturation of the signed fixed-point quotients.
// ----------------------------------------------------------------------------
module efj_div #(
  parameter int unsigned WordBits = efj_pkg::DefWordBits,
  parameter int unsigned FracBits = efj_pkg::DefFracBits,
  parameter int unsigned SideBits = 1
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  efj_pkg::efj_ctl_t               ctl_i,
  input  wire logic signed [WordBits-1:0] num_a_i,
  input  wire logic signed [WordBits-1:0] num_b_i,
  input  wire logic        [WordBits-1:0] den_i,
  input  wire logic        [SideBits-1:0] side_i,
  output efj_pkg::efj_ctl_t               ctl_o,
  output logic signed      [WordBits-1:0] quo_a_o,
  output logic signed      [WordBits-1:0] quo_b_o,
  output logic             [SideBits-1:0] side_o
);
  import efj_pkg::*;

  localparam int unsigned NumBits = WordBits + FracBits;
  localparam int unsigned Steps = DivStepsPerStage;
  localparam int unsigned Stages = (NumBits + Steps - 1) / Steps;

  logic [WordBits-1:0] rem_a_q [Stages];
  logic [WordBits-1:0] rem_b_q [Stages];
  logic [NumBits-1:0]  num_a_q [Stages];
  logic [NumBits-1:0]  num_b_q [Stages];
  logic [WordBits-1:0] den_q   [Stages];
  logic                neg_a_q [Stages];
  logic                neg_b_q [Stages];
  efj_ctl_t            ctl_q   [Stages];
  logic [SideBits-1:0] side_q  [Stages];

  function automatic logic [WordBits+NumBits-1:0] div_steps(
    input logic [WordBits-1:0] rem,
    input logic [NumBits-1:0]  num,
    input logic [WordBits-1:0] den,
    input int unsigned         cnt
  );
    logic [WordBits-1:0] r;
    logic [NumBits-1:0]  q;
    logic [WordBits:0]   t;
    r = rem;
    q = num;
    for (int k = 0; k < Steps; k++) begin
      if (k < cnt) begin
        t = {r, q[NumBits-1]};
        q = {q[NumBits-2:0], 1'b0};
        if (t >= {1'b0, den}) begin
          t = t - {1'b0, den};
          q[0] = 1'b1;
        end
        r = t[WordBits-1:0];
      end
    end
    return {r, q};
  endfunction

  function automatic logic [WordBits:0] pack_q(
    input logic              neg,
    input logic [NumBits-1:0] q
  );
    logic [NumBits-1:0]  lim;
    logic                ovf;
    logic [WordBits-1:0] v;
    lim = {{FracBits{1'b0}}, 1'b1, {(WordBits-1){1'b0}}} - {{(NumBits-1){1'b0}}, ~neg};
    ovf = q > lim;
    v = ovf ? lim[WordBits-1:0] : q[WordBits-1:0];
    return {ovf, (neg ? (~v + 1'b1) : v)};
  endfunction

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    localparam int unsigned Cnt = (NumBits - s * Steps >= Steps) ? Steps : NumBits - s * Steps;
    logic [WordBits-1:0] rem_a_in, rem_b_in, den_in, rem_a_nx, rem_b_nx;
    logic [NumBits-1:0]  num_a_in, num_b_in, num_a_nx, num_b_nx;
    logic                neg_a_in, neg_b_in;
    efj_ctl_t            ctl_in;
    logic [SideBits-1:0] side_in;

    if (s == 0) begin : g_first
      logic [WordBits-1:0] mag_a, mag_b;
      assign mag_a = num_a_i[WordBits-1] ? (~num_a_i + 1'b1) : num_a_i;
      assign mag_b = num_b_i[WordBits-1] ? (~num_b_i + 1'b1) : num_b_i;
      assign rem_a_in = '0;
      assign rem_b_in = '0;
      assign num_a_in = {mag_a, {FracBits{1'b0}}};
      assign num_b_in = {mag_b, {FracBits{1'b0}}};
      assign den_in   = den_i;
      assign neg_a_in = num_a_i[WordBits-1];
      assign neg_b_in = num_b_i[WordBits-1];
      assign ctl_in   = ctl_i;
      assign side_in  = side_i;
    end else begin : g_next
      assign rem_a_in = rem_a_q[s-1];
      assign rem_b_in = rem_b_q[s-1];
      assign num_a_in = num_a_q[s-1];
      assign num_b_in = num_b_q[s-1];
      assign den_in   = den_q[s-1];
      assign neg_a_in = neg_a_q[s-1];
      assign neg_b_in = neg_b_q[s-1];
      assign ctl_in   = ctl_q[s-1];
      assign side_in  = side_q[s-1];
    end

    assign {rem_a_nx, num_a_nx} = div_steps(rem_a_in, num_a_in, den_in, Cnt);
    assign {rem_b_nx, num_b_nx} = div_steps(rem_b_in, num_b_in, den_in, Cnt);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[s] <= '0;
      end else begin
        ctl_q[s] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_a_q[s] <= rem_a_nx;
      rem_b_q[s] <= rem_b_nx;
      num_a_q[s] <= num_a_nx;
      num_b_q[s] <= num_b_nx;
      den_q[s]   <= den_in;
      neg_a_q[s] <= neg_a_in;
      neg_b_q[s] <= neg_b_in;
      side_q[s]  <= side_in;
    end
  end

  logic [WordBits:0] res_a, res_b;
  efj_ctl_t          ctl_d;

  assign res_a = pack_q(neg_a_q[Stages-1], num_a_q[Stages-1]);
  assign res_b = pack_q(neg_b_q[Stages-1], num_b_q[Stages-1]);

  always_comb begin
    ctl_d = ctl_q[Stages-1];
    ctl_d.clip = ctl_q[Stages-1].clip | res_a[WordBits] | res_b[WordBits];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_a_o <= res_a[WordBits-1:0];
    quo_b_o <= res_b[WordBits-1:0];
    side_o  <= side_q[Stages-1];
  end

endmodule
`default_nettype wire

FILE: sv/efj_post.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Flux and Jacobian datapath
// Four register stages of saturating products and sums that turn velocity,
// specific energy and the gas constants into the flux and Jacobian terms.
// ----------------------------------------------------------------------------
module efj_post #(
  parameter int unsigned WordBits = efj_pkg::DefWordBits,
  parameter int unsigned FracBits = efj_pkg::DefFracBits
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  efj_pkg::efj_ctl_t               ctl_i,
  input  wire logic signed [WordBits-1:0] u_i,
  input  wire logic signed [WordBits-1:0] e_i,
  input  wire logic signed [WordBits-1:0] m_i,
  input  wire logic signed [WordBits-1:0] en_i,
  input  wire logic signed [WordBits-1:0] g_i,
  input  wire logic signed [WordBits-1:0] gm1_i,
  input  wire logic signed [WordBits-1:0] tmg_i,
  output logic                            done_o,
  output logic signed      [WordBits-1:0] mass_flux_o,
  output logic signed      [WordBits-1:0] momentum_flux_o,
  output logic signed      [WordBits-1:0] energy_flux_o,
  output logic signed      [WordBits-1:0] velocity_o,
  output logic signed      [WordBits-1:0] pressure_o,
  output logic signed      [WordBits-1:0] jac_mom_by_density_o,
  output logic signed      [WordBits-1:0] jac_mom_by_momentum_o,
  output logic signed      [WordBits-1:0] jac_energy_by_density_o,
  output logic signed      [WordBits-1:0] jac_energy_by_momentum_o,
  output logic signed      [WordBits-1:0] jac_energy_by_energy_o,
  output efj_pkg::status_e                status_o
);
  import efj_pkg::*;

  typedef logic signed [WordBits-1:0] word_t;
  typedef struct packed {
    logic  clip;
    word_t val;
  } sres_t;

  localparam logic [127:0] WordMaxU = (128'd1 << (WordBits - 1)) - 128'd1;
  localparam logic [127:0] HalfRaw = 128'd1 << (FracBits - 1);
  localparam logic [127:0] ThreeHalfRaw = 128'd3 << (FracBits - 1);
  localparam logic HalfClip = HalfRaw > WordMaxU;
  localparam logic ThreeHalfClip = ThreeHalfRaw > WordMaxU;
  localparam word_t Half = HalfClip ? WordMaxU[WordBits-1:0] : HalfRaw[WordBits-1:0];
  localparam word_t ThreeHalf =
      ThreeHalfClip ? WordMaxU[WordBits-1:0] : ThreeHalfRaw[WordBits-1:0];

  function automatic sres_t add_s(input word_t a, input word_t b);
    logic [WordBits:0] s;
    sres_t             r;
    s = {a[WordBits-1], a} + {b[WordBits-1], b};
    r.clip = s[WordBits] ^ s[WordBits-1];
    r.val = r.clip ? {s[WordBits], {(WordBits-1){~s[WordBits]}}} : s[WordBits-1:0];
    return r;
  endfunction

  function automatic sres_t sub_s(input word_t a, input word_t b);
    logic [WordBits:0] s;
    sres_t             r;
    s = {a[WordBits-1], a} - {b[WordBits-1], b};
    r.clip = s[WordBits] ^ s[WordBits-1];
    r.val = r.clip ? {s[WordBits], {(WordBits-1){~s[WordBits]}}} : s[WordBits-1:0];
    return r;
  endfunction

  function automatic sres_t mul_s(input word_t a, input word_t b);
    logic [WordBits-1:0]   ma, mb;
    logic [2*WordBits-1:0] p, lim;
    logic                  neg;
    sres_t                 r;
    ma = a[WordBits-1] ? (~a + 1'b1) : a;
    mb = b[WordBits-1] ? (~b + 1'b1) : b;
    p = ma * mb;
    p = p >> FracBits;
    neg = a[WordBits-1] ^ b[WordBits-1];
    lim = {{WordBits{1'b0}}, 1'b1, {(WordBits-1){1'b0}}} - {{(2*WordBits-1){1'b0}}, ~neg};
    r.clip = p > lim;
    if (r.clip) begin
      p = lim;
    end
    r.val = neg ? word_t'(~p[WordBits-1:0] + 1'b1) : word_t'(p[WordBits-1:0]);
    return r;
  endfunction

  // Stage 1
  sres_t s1_mu, s1_u2, s1_uen, s1_uee, s1_gu, s1_tu, s1_ge;
  sres_t s1_htmg, s1_hgm1, s1_thgm1, s1_gen;
  efj_ctl_t s1_ctl_d, s1_ctl_q;
  word_t s1_mu_q, s1_u2_q, s1_uen_q, s1_uee_q, s1_gu_q, s1_tu_q, s1_ge_q;
  word_t s1_htmg_q, s1_hgm1_q, s1_thgm1_q, s1_gen_q;
  word_t s1_u_q, s1_m_q, s1_en_q, s1_g_q, s1_gm1_q;

  assign s1_mu    = mul_s(m_i, u_i);
  assign s1_u2    = mul_s(u_i, u_i);
  assign s1_uen   = mul_s(u_i, en_i);
  assign s1_uee   = mul_s(u_i, e_i);
  assign s1_gu    = mul_s(g_i, u_i);
  assign s1_tu    = mul_s(tmg_i, u_i);
  assign s1_ge    = mul_s(g_i, e_i);
  assign s1_htmg  = mul_s(Half, tmg_i);
  assign s1_hgm1  = mul_s(Half, gm1_i);
  assign s1_thgm1 = mul_s(ThreeHalf, gm1_i);
  assign s1_gen   = mul_s(gm1_i, en_i);

  always_comb begin
    s1_ctl_d = ctl_i;
    s1_ctl_d.clip = ctl_i.clip | HalfClip | ThreeHalfClip | s1_mu.clip | s1_u2.clip
                  | s1_uen.clip | s1_uee.clip | s1_gu.clip | s1_tu.clip | s1_ge.clip
                  | s1_htmg.clip | s1_hgm1.clip | s1_thgm1.clip | s1_gen.clip;
  end

  // Stage 2
  sres_t s2_a1, s2_b1, s2_b2, s2_hmu, s2_c1, s2_d1, s2_d2, s2_e2;
  efj_ctl_t s2_ctl_d, s2_ctl_q;
  word_t s2_a1_q, s2_b1_q, s2_b2_q, s2_hmu_q, s2_c1_q, s2_d1_q, s2_d2_q, s2_e2_q;
  word_t s2_gen_q, s2_hgm1_q, s2_gm1_q, s2_en_q, s2_ge_q, s2_gu_q, s2_tu_q;
  word_t s2_u_q, s2_m_q;

  assign s2_a1  = mul_s(s1_htmg_q, s1_mu_q);
  assign s2_b1  = mul_s(s1_g_q, s1_uen_q);
  assign s2_b2  = mul_s(s1_mu_q, s1_u_q);
  assign s2_hmu = mul_s(Half, s1_mu_q);
  assign s2_c1  = mul_s(s1_htmg_q, s1_u2_q);
  assign s2_d1  = mul_s(s1_g_q, s1_uee_q);
  assign s2_d2  = mul_s(s1_u2_q, s1_u_q);
  assign s2_e2  = mul_s(s1_thgm1_q, s1_u2_q);

  always_comb begin
    s2_ctl_d = s1_ctl_q;
    s2_ctl_d.clip = s1_ctl_q.clip | s2_a1.clip | s2_b1.clip | s2_b2.clip | s2_hmu.clip
                  | s2_c1.clip | s2_d1.clip | s2_d2.clip | s2_e2.clip;
  end

  // Stage 3
  sres_t s3_b3, s3_p1, s3_d3, s3_r1, s3_r5, s3_r7a, s3_r8;
  efj_ctl_t s3_ctl_d, s3_ctl_q;
  word_t s3_b3_q, s3_p1_q, s3_d3_q, s3_r1_q, s3_r5_q, s3_r7a_q, s3_r8_q;
  word_t s3_b1_q, s3_gm1_q, s3_u_q, s3_tu_q, s3_gu_q, s3_m_q;

  assign s3_b3  = mul_s(s2_hgm1_q, s2_b2_q);
  assign s3_p1  = sub_s(s2_en_q, s2_hmu_q);
  assign s3_d3  = mul_s(s2_gm1_q, s2_d2_q);
  assign s3_r1  = add_s(s2_a1_q, s2_gen_q);
  assign s3_r5  = sub_s('0, s2_c1_q);
  assign s3_r7a = sub_s('0, s2_d1_q);
  assign s3_r8  = sub_s(s2_ge_q, s2_e2_q);

  always_comb begin
    s3_ctl_d = s2_ctl_q;
    s3_ctl_d.clip = s2_ctl_q.clip | s3_b3.clip | s3_p1.clip | s3_d3.clip | s3_r1.clip
                  | s3_r5.clip | s3_r7a.clip | s3_r8.clip;
  end

  // Stage 4
  sres_t s4_r2, s4_r4, s4_r7;
  logic s4_clip, s4_bad;

  assign s4_r2 = sub_s(s3_b1_q, s3_b3_q);
  assign s4_r4 = mul_s(s3_gm1_q, s3_p1_q);
  assign s4_r7 = add_s(s3_r7a_q, s3_d3_q);
  assign s4_bad = s3_ctl_q.bad;
  assign s4_clip = s3_ctl_q.clip | s4_r2.clip | s4_r4.clip | s4_r7.clip;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
      s2_ctl_q <= '0;
      s3_ctl_q <= '0;
      done_o   <= 1'b0;
    end else begin
      s1_ctl_q <= s1_ctl_d;
      s2_ctl_q <= s2_ctl_d;
      s3_ctl_q <= s3_ctl_d;
      done_o   <= s3_ctl_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_mu_q    <= s1_mu.val;
    s1_u2_q    <= s1_u2.val;
    s1_uen_q   <= s1_uen.val;
    s1_uee_q   <= s1_uee.val;
    s1_gu_q    <= s1_gu.val;
    s1_tu_q    <= s1_tu.val;
    s1_ge_q    <= s1_ge.val;
    s1_htmg_q  <= s1_htmg.val;
    s1_hgm1_q  <= s1_hgm1.val;
    s1_thgm1_q <= s1_thgm1.val;
    s1_gen_q   <= s1_gen.val;
    s1_u_q     <= u_i;
    s1_m_q     <= m_i;
    s1_en_q    <= en_i;
    s1_g_q     <= g_i;
    s1_gm1_q   <= gm1_i;

    s2_a1_q   <= s2_a1.val;
    s2_b1_q   <= s2_b1.val;
    s2_b2_q   <= s2_b2.val;
    s2_hmu_q  <= s2_hmu.val;
    s2_c1_q   <= s2_c1.val;
    s2_d1_q   <= s2_d1.val;
    s2_d2_q   <= s2_d2.val;
    s2_e2_q   <= s2_e2.val;
    s2_gen_q  <= s1_gen_q;
    s2_hgm1_q <= s1_hgm1_q;
    s2_gm1_q  <= s1_gm1_q;
    s2_en_q   <= s1_en_q;
    s2_ge_q   <= s1_ge_q;
    s2_gu_q   <= s1_gu_q;
    s2_tu_q   <= s1_tu_q;
    s2_u_q    <= s1_u_q;
    s2_m_q    <= s1_m_q;

    s3_b3_q  <= s3_b3.val;
    s3_p1_q  <= s3_p1.val;
    s3_d3_q  <= s3_d3.val;
    s3_r1_q  <= s3_r1.val;
    s3_r5_q  <= s3_r5.val;
    s3_r7a_q <= s3_r7a.val;
    s3_r8_q  <= s3_r8.val;
    s3_b1_q  <= s2_b1_q;
    s3_gm1_q <= s2_gm1_q;
    s3_u_q   <= s2_u_q;
    s3_tu_q  <= s2_tu_q;
    s3_gu_q  <= s2_gu_q;
    s3_m_q   <= s2_m_q;

    mass_flux_o <= s3_m_q;
    if (s4_bad) begin
      momentum_flux_o          <= '0;
      energy_flux_o            <= '0;
      velocity_o               <= '0;
      pressure_o               <= '0;
      jac_mom_by_density_o     <= '0;
      jac_mom_by_momentum_o    <= '0;
      jac_energy_by_density_o  <= '0;
      jac_energy_by_momentum_o <= '0;
      jac_energy_by_energy_o   <= '0;
      status_o                 <= StatusBadDensity;
    end else begin
      momentum_flux_o          <= s3_r1_q;
      energy_flux_o            <= s4_r2.val;
      velocity_o               <= s3_u_q;
      pressure_o               <= s4_r4.val;
      jac_mom_by_density_o     <= s3_r5_q;
      jac_mom_by_momentum_o    <= s3_tu_q;
      jac_energy_by_density_o  <= s4_r7.val;
      jac_energy_by_momentum_o <= s3_r8_q;
      jac_energy_by_energy_o   <= s3_gu_q;
      status_o                 <= s4_clip ? StatusSaturated : StatusOk;
    end
  end

endmodule
`default_nettype wire

FILE: sv/euler_flux_jacobian_unit_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Euler flux and Jacobian unit
// One-dimensional Euler flux, primitive variables and flux Jacobian per cell.
// ----------------------------------------------------------------------------
// A cell request is taken on a clock edge where start is high and busy is
// low; busy stays low, so a new cell may be issued in every cycle. Density,
// momentum and total energy are signed fixed-point words.
// Each result appears on the result ports for exactly one cycle with done_o
// high, in request order. The two divisions retire eight quotient bits per
// stage, followed by one output stage of the divider and four stages of
// products and sums. Throughput is one cell per cycle.
// The receiver cannot hold results off and the pipeline never stalls.
// The heat ratio register lives at byte address 0 of the APB port and is
// sampled as a request enters. Reset clears all valid bits and loads the
// heat ratio with its default of about 1.4.
// A density of zero or below yields status 1 with all results but the mass
// flux cleared; any saturation along the way yields status 2.
// ----------------------------------------------------------------------------
module euler_flux_jacobian_unit_core #(
  parameter int unsigned WordBits = efj_pkg::DefWordBits,
  parameter int unsigned FracBits = efj_pkg::DefFracBits
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   psel,
  input  wire                                   penable,
  input  wire                                   pwrite,
  input  wire logic [efj_pkg::AddrBits-1:0]     paddr,
  input  wire logic [31:0]                      pwdata,
  output logic      [31:0]                      prdata,
  output logic                                  pready,
  input  wire                                   start,
  output logic                                  busy,
  input  wire logic signed [WordBits-1:0]       density_i,
  input  wire logic signed [WordBits-1:0]       momentum_i,
  input  wire logic signed [WordBits-1:0]       total_energy_i,
  output logic                                  done_o,
  output logic signed      [WordBits-1:0]       mass_flux_o,
  output logic signed      [WordBits-1:0]       momentum_flux_o,
  output logic signed      [WordBits-1:0]       energy_flux_o,
  output logic signed      [WordBits-1:0]       velocity_o,
  output logic signed      [WordBits-1:0]       pressure_o,
  output logic signed      [WordBits-1:0]       jac_mom_by_density_o,
  output logic signed      [WordBits-1:0]       jac_mom_by_momentum_o,
  output logic signed      [WordBits-1:0]       jac_energy_by_density_o,
  output logic signed      [WordBits-1:0]       jac_energy_by_momentum_o,
  output logic signed      [WordBits-1:0]       jac_energy_by_energy_o,
  output efj_pkg::status_e                      status_o
);
  import efj_pkg::*;

  localparam int unsigned DivStages =
      (WordBits + FracBits + DivStepsPerStage - 1) / DivStepsPerStage;
  localparam int unsigned Latency = DivStages + 5;
  localparam int unsigned SideBits = 5 * WordBits;

  localparam logic [127:0] WordMaxU = (128'd1 << (WordBits - 1)) - 128'd1;
  localparam logic [127:0] OneRaw = 128'd1 << FracBits;
  localparam logic [127:0] ThreeRaw = 128'd3 << FracBits;
  localparam logic OneClip = OneRaw > WordMaxU;
  localparam logic ThreeClip = ThreeRaw > WordMaxU;
  localparam logic [WordBits-1:0] One =
      OneClip ? WordMaxU[WordBits-1:0] : OneRaw[WordBits-1:0];
  localparam logic [WordBits-1:0] Three =
      ThreeClip ? WordMaxU[WordBits-1:0] : ThreeRaw[WordBits-1:0];

  logic [HeatBits-1:0] heat_q;
  logic                heat_we;

  assign pready = 1'b1;
  assign busy = 1'b0;
  assign heat_we = psel && penable && pwrite && (paddr[AddrBits-1] == RegHeatRatio);
  assign prdata = (paddr[AddrBits-1] == RegHeatRatio) ? {{(32-HeatBits){1'b0}}, heat_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heat_q <= HeatReset;
    end else if (heat_we) begin
      heat_q <= pwdata[HeatBits-1:0];
    end
  end

  logic [127:0]        gq_wide;
  logic                g_clip;
  logic [WordBits-1:0] g_val;
  logic [WordBits:0]   gm1_s, tmg_s;
  logic                gm1_clip, tmg_clip;
  logic [WordBits-1:0] gm1_val, tmg_val;

  if (FracBits >= HeatFracBits) begin : g_gq_up
    assign gq_wide = 128'(heat_q) << (FracBits - HeatFracBits);
  end else begin : g_gq_down
    assign gq_wide = 128'(heat_q) >> (HeatFracBits - FracBits);
  end

  assign g_clip = gq_wide > WordMaxU;
  assign g_val  = g_clip ? WordMaxU[WordBits-1:0] : gq_wide[WordBits-1:0];

  assign gm1_s    = {g_val[WordBits-1], g_val} - {One[WordBits-1], One};
  assign gm1_clip = gm1_s[WordBits] ^ gm1_s[WordBits-1];
  assign gm1_val  = gm1_clip ? {gm1_s[WordBits], {(WordBits-1){~gm1_s[WordBits]}}}
                             : gm1_s[WordBits-1:0];
  assign tmg_s    = {Three[WordBits-1], Three} - {g_val[WordBits-1], g_val};
  assign tmg_clip = tmg_s[WordBits] ^ tmg_s[WordBits-1];
  assign tmg_val  = tmg_clip ? {tmg_s[WordBits], {(WordBits-1){~tmg_s[WordBits]}}}
                             : tmg_s[WordBits-1:0];

  efj_ctl_t            in_ctl, div_ctl;
  logic [SideBits-1:0] div_side_in, div_side_out;
  logic signed [WordBits-1:0] div_u, div_e;
  logic signed [WordBits-1:0] side_m, side_en, side_g, side_gm1, side_tmg;

  assign in_ctl.valid = start && !busy;
  assign in_ctl.bad   = density_i[WordBits-1] || (density_i == '0);
  assign in_ctl.clip  = OneClip | ThreeClip | g_clip | gm1_clip | tmg_clip;
  assign div_side_in  = {momentum_i, total_energy_i, g_val, gm1_val, tmg_val};
  assign {side_m, side_en, side_g, side_gm1, side_tmg} = div_side_out;

  efj_div #(
    .WordBits(WordBits),
    .FracBits(FracBits),
    .SideBits(SideBits)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (in_ctl),
    .num_a_i(momentum_i),
    .num_b_i(total_energy_i),
    .den_i  (density_i),
    .side_i (div_side_in),
    .ctl_o  (div_ctl),
    .quo_a_o(div_u),
    .quo_b_o(div_e),
    .side_o (div_side_out)
  );

  efj_post #(
    .WordBits(WordBits),
    .FracBits(FracBits)
  ) u_post (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .ctl_i                   (div_ctl),
    .u_i                     (div_u),
    .e_i                     (div_e),
    .m_i                     (side_m),
    .en_i                    (side_en),
    .g_i                     (side_g),
    .gm1_i                   (side_gm1),
    .tmg_i                   (side_tmg),
    .done_o                  (done_o),
    .mass_flux_o             (mass_flux_o),
    .momentum_flux_o         (momentum_flux_o),
    .energy_flux_o           (energy_flux_o),
    .velocity_o              (velocity_o),
    .pressure_o              (pressure_o),
    .jac_mom_by_density_o    (jac_mom_by_density_o),
    .jac_mom_by_momentum_o   (jac_mom_by_momentum_o),
    .jac_energy_by_density_o (jac_energy_by_density_o),
    .jac_energy_by_momentum_o(jac_energy_by_momentum_o),
    .jac_energy_by_energy_o  (jac_energy_by_energy_o),
    .status_o                (status_o)
  );

  a_request_completes: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (start && !busy) |-> ##Latency done_o)
    else $error("request did not complete after the pipeline latency");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
      done_o |-> $past(start, Latency))
    else $error("result without a matching request");

  a_mass_flux_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
      done_o |-> (mass_flux_o == $past(momentum_i, Latency)))
    else $error("mass flux does not match the request momentum");

  a_bad_density_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (done_o && status_o == StatusBadDensity) |-> (velocity_o == '0 && pressure_o == '0))
    else $error("results not cleared for a non-positive density");

endmodule
`default_nettype wire

FILE: verif/tb_euler_flux_jacobian_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler flux and Jacobian unit testbench
// Streams cell requests through the core in random bursts under several heat
// ratio settings. An in-bench fixed-point predictor computes the expected
// fluxes, primitives, Jacobian entries and status. Each strobed result is
// compared field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_euler_flux_jacobian_unit_core;
  import efj_pkg::*;

  localparam int unsigned NumWords = 10;
  localparam int unsigned LatencyCycles = 11;
  localparam int unsigned StallLimit = 5000;

  typedef struct {
    logic [31:0] words[NumWords];
    status_e     st;
  } cell_result_t;

  typedef struct {
    logic [31:0] rho;
    logic [31:0] mom;
    logic [31:0] en;
  } cell_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [AddrBits-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic signed [31:0] density_i = '0;
  logic signed [31:0] momentum_i = '0;
  logic signed [31:0] total_energy_i = '0;
  logic        done_o;
  logic signed [31:0] out_words[NumWords];
  status_e     status_o;

  cell_t        pending_cells[$];
  cell_result_t expected_cells[$];
  logic [HeatBits-1:0] heat_model = HeatReset;
  int unsigned  mismatch_count = 0;
  int unsigned  idle_cycles = 0;
  bit           hold_requests = 1'b0;
  bit           clip_flag;
  int unsigned  burst_left = 0;
  int unsigned  gap_left = 0;
  string        word_names[NumWords] = '{"mass_flux", "momentum_flux", "energy_flux",
    "velocity", "pressure", "jac_mom_by_density", "jac_mom_by_momentum",
    "jac_energy_by_density", "jac_energy_by_momentum", "jac_energy_by_energy"};

  euler_flux_jacobian_unit_core u_dut (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .psel                     (psel),
    .penable                  (penable),
    .pwrite                   (pwrite),
    .paddr                    (paddr),
    .pwdata                   (pwdata),
    .prdata                   (prdata),
    .pready                   (pready),
    .start                    (start),
    .busy                     (busy),
    .density_i                (density_i),
    .momentum_i               (momentum_i),
    .total_energy_i           (total_energy_i),
    .done_o                   (done_o),
    .mass_flux_o              (out_words[0]),
    .momentum_flux_o          (out_words[1]),
    .energy_flux_o            (out_words[2]),
    .velocity_o               (out_words[3]),
    .pressure_o               (out_words[4]),
    .jac_mom_by_density_o     (out_words[5]),
    .jac_mom_by_momentum_o    (out_words[6]),
    .jac_energy_by_density_o  (out_words[7]),
    .jac_energy_by_momentum_o (out_words[8]),
    .jac_energy_by_energy_o   (out_words[9]),
    .status_o                 (status_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [63:0] mag_of(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint clamp_mag(bit neg, logic [63:0] m);
    logic [63:0] lim;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (m > lim) begin
      clip_flag = 1'b1;
      m = lim;
    end
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp_word(longint v);
    if (v > 64'sh7FFF_FFFF) begin
      clip_flag = 1'b1;
      return 64'sh7FFF_FFFF;
    end
    if (v < -64'sh8000_0000) begin
      clip_flag = 1'b1;
      return -64'sh8000_0000;
    end
    return v;
  endfunction

  function automatic longint fx_add(longint a, longint b);
    return clamp_word(a + b);
  endfunction

  function automatic longint fx_sub(longint a, longint b);
    return clamp_word(a - b);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    logic [63:0] p;
    p = (mag_of(a) * mag_of(b)) >> DefFracBits;
    return clamp_mag((a < 0) != (b < 0), p);
  endfunction

  function automatic longint fx_div(longint a, longint b);
    logic [63:0] q;
    q = (mag_of(a) << DefFracBits) / 64'(b);
    return clamp_mag(a < 0, q);
  endfunction

  function automatic cell_result_t predict_cell(cell_t c, logic [HeatBits-1:0] heat);
    cell_result_t r;
    longint rho, m, en, one, half, three_half, three, g, gm1, tmg, u, e, mu, u2;
    longint v[NumWords];
    rho = longint'(signed'(c.rho));
    m = longint'(signed'(c.mom));
    en = longint'(signed'(c.en));
    clip_flag = 1'b0;
    foreach (v[k]) v[k] = 0;
    v[0] = m;
    r.st = StatusBadDensity;
    if (rho > 0) begin
      one = 64'sd1 << DefFracBits;
      half = 64'sd1 << (DefFracBits - 1);
      three_half = 64'sd3 << (DefFracBits - 1);
      three = 64'sd3 << DefFracBits;
      g = longint'(heat);
      gm1 = fx_sub(g, one);
      tmg = fx_sub(three, g);
      u = fx_div(m, rho);
      e = fx_div(en, rho);
      mu = fx_mul(m, u);
      u2 = fx_mul(u, u);
      v[1] = fx_add(fx_mul(fx_mul(half, tmg), mu), fx_mul(gm1, en));
      v[2] = fx_sub(fx_mul(g, fx_mul(u, en)), fx_mul(fx_mul(half, gm1), fx_mul(mu, u)));
      v[3] = u;
      v[4] = fx_mul(gm1, fx_sub(en, fx_mul(half, mu)));
      v[5] = fx_sub(0, fx_mul(fx_mul(half, tmg), u2));
      v[6] = fx_mul(tmg, u);
      v[7] = fx_add(fx_sub(0, fx_mul(g, fx_mul(u, e))), fx_mul(gm1, fx_mul(u2, u)));
      v[8] = fx_sub(fx_mul(g, e), fx_mul(fx_mul(three_half, gm1), u2));
      v[9] = fx_mul(g, u);
      r.st = clip_flag ? StatusSaturated : StatusOk;
    end
    foreach (v[k]) r.words[k] = v[k][31:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH %s", msg);
    mismatch_count++;
  endtask

  // Request driver: presents cells in bursts separated by random gaps.
  always @(posedge clk_i) begin
    cell_t nxt;
    bit issue;
    if (rst_ni) begin
      if (start && !busy) begin
        nxt.rho = density_i;
        nxt.mom = momentum_i;
        nxt.en = total_energy_i;
        expected_cells.push_back(predict_cell(nxt, heat_model));
      end
      issue = 1'b0;
      if (start && busy) begin
        issue = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (!hold_requests && pending_cells.size() > 0) begin
        nxt = pending_cells.pop_front();
        density_i <= nxt.rho;
        momentum_i <= nxt.mom;
        total_energy_i <= nxt.en;
        issue = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      start <= issue;
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    cell_result_t want;
    if (rst_ni && done_o) begin
      if (expected_cells.size() == 0) begin
        report_mismatch("result strobe with no request outstanding");
      end else begin
        want = expected_cells.pop_front();
        foreach (want.words[k]) begin
          if (out_words[k] !== want.words[k]) begin
            report_mismatch($sformatf("%s: got %h, expected %h", word_names[k],
                                      out_words[k], want.words[k]));
          end
        end
        if (status_o !== want.st) begin
          report_mismatch($sformatf("status: got %h, expected %h", status_o, want.st));
        end
      end
    end
  end

  // Watchdog on cycles with no request or result accepted.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_heat_ratio(logic [HeatBits-1:0] value);
    logic [31:0] rd;
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= AddrBits'(4 * RegHeatRatio);
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    heat_model = value;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    rd = prdata;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd[HeatBits-1:0] !== value) begin
      report_mismatch($sformatf("heat_ratio readback: got %h, expected %h", rd, value));
    end
  endtask

  task automatic queue_cell(logic [31:0] rho, logic [31:0] mom, logic [31:0] en);
    cell_t c;
    c.rho = rho;
    c.mom = mom;
    c.en = en;
    pending_cells.push_back(c);
  endtask

  task automatic queue_random_cells(int unsigned count);
    logic [31:0] rho;
    logic signed [63:0] vel;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0, 1: queue_cell($urandom, $urandom, $urandom);
        2: queue_cell(-$urandom_range(0, 1 << 20), $urandom, $urandom);
        default: begin
          rho = $urandom_range(1 << 10, 16 << 16);
          vel = $signed(64'($urandom_range(0, 8 << 16))) - (4 << 16);
          queue_cell(rho, 32'((64'(rho) * vel) >>> 16), $urandom_range(0, 64 << 16));
        end
      endcase
    end
  endtask

  task automatic drain;
    wait (pending_cells.size() == 0 && !start && expected_cells.size() == 0);
    repeat (LatencyCycles) @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_cell(32'h0001_0000, 32'h0002_0000, 32'h000A_0000);
    queue_cell(32'h0000_0000, 32'h1234_5678, 32'h0001_0000);
    queue_cell(32'hFFFF_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_cell(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_cell(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    queue_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_cell(32'h0000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_cell(32'h0000_0001, 32'h8000_0000, 32'h8000_0000);
    queue_cell(32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
    queue_cell(32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
    queue_cell(32'h0001_0000, 32'hFFFF_0000, 32'h0001_8000);
    queue_cell(32'h0000_8000, 32'h0100_0000, 32'h0100_0000);
    queue_cell(32'h0010_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cell(32'h0000_0100, 32'h0001_0000, 32'hFFF0_0000);
    queue_cell(32'h0002_0000, 32'h0003_0000, 32'h0005_0000);
    queue_cell(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001);
    queue_random_cells(80);
    drain();

    // Low, high, random and reset heat ratios, each followed by traffic.
    write_heat_ratio(18'd65536);
    queue_cell(32'h0001_0000, 32'h0002_0000, 32'h000A_0000);
    queue_random_cells(85);
    drain();
    write_heat_ratio(18'd196608);
    queue_cell(32'h0001_0000, 32'h0002_0000, 32'h000A_0000);
    queue_random_cells(85);
    drain();
    write_heat_ratio(18'($urandom_range(65536, 196608)));
    queue_random_cells(85);
    wait (pending_cells.size() < 40);
    hold_requests = 1'b1;
    wait (expected_cells.size() == 0 && !start);
    hold_requests = 1'b0;
    drain();
    write_heat_ratio(HeatReset);
    queue_random_cells(85);
    drain();

    repeat (LatencyCycles + 5) @(posedge clk_i);
    while (expected_cells.size() > 0) begin
      void'(expected_cells.pop_front());
      report_mismatch("expected result never arrived");
    end
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
